// ----- rtl/core/color_window_centroid_tracker_unit_macros.svh -----
// ============================================================================
// Assertion macros for the color window centroid tracker
// Implication checks on the block clock, disabled while reset is held.
// ============================================================================
`ifndef COLOR_WINDOW_CENTROID_TRACKER_UNIT_MACROS_SVH
`define COLOR_WINDOW_CENTROID_TRACKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define CWCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cwct assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CWCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cwct assertion failed");

`else

`define CWCT_ASSERT_SAME(lbl, ante, cons)
`define CWCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/cwct_pkg.sv -----
// ============================================================================
// cwct_pkg
// Shared widths, reset values, register indexes and interface types.
// ============================================================================
package cwct_pkg;

    localparam int COLOR_W   = 8;
    localparam int COORD_W   = 10;
    localparam int HALF_W    = 7;
    localparam int CNT_W     = 16;
    // Sums never exceed the saturated count times the largest coordinate.
    localparam int SUM_W     = COORD_W + CNT_W;
    localparam int STEP_W    = $clog2(COORD_W);
    localparam int CFG_IDX_W = 2;
    localparam int WIN_W     = COORD_W + 1;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int POS_CMP_W  = 13;

    localparam logic [COORD_W-1:0] CENTER_RESET = COORD_W'(150);
    localparam logic [HALF_W-1:0]  HALF_RESET   = HALF_W'(65);
    localparam logic [COLOR_W-1:0] MARGIN_RESET = COLOR_W'(21);
    localparam logic [COLOR_W-1:0] FLOOR_RESET  = COLOR_W'(170);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BR_MARGIN  = 2'd0,
        CFG_BG_MARGIN  = 2'd1,
        CFG_BLUE_FLOOR = 2'd2,
        CFG_WIN_HALF   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic pix_acc;
        logic div_load;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

endpackage

// ----- rtl/core/cwct_div.sv -----
// ============================================================================
// cwct_div
// Restoring divider, one quotient bit per step, for a quotient below 2^COORD_W.
// ============================================================================
module cwct_div (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_step,
    input  logic [cwct_pkg::SUM_W-1:0]       i_dividend,
    input  logic [cwct_pkg::CNT_W-1:0]       i_divisor,
    output logic [cwct_pkg::COORD_W-1:0]     o_quotient
);

    logic [cwct_pkg::CNT_W-1:0]   r_rem;
    logic [cwct_pkg::COORD_W-1:0] r_q;
    logic [cwct_pkg::CNT_W:0]     trial;
    logic                         q_bit;

    // The upper dividend bits are below the divisor because the mean of
    // in-range coordinates fits the coordinate width.
    always_comb begin
        trial = {r_rem, r_q[cwct_pkg::COORD_W-1]};
        q_bit = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_dividend[cwct_pkg::SUM_W-1:cwct_pkg::COORD_W];
            r_q   <= i_dividend[cwct_pkg::COORD_W-1:0];
        end else if (i_step) begin
            if (q_bit) begin
                r_rem <= cwct_pkg::CNT_W'(trial - {1'b0, i_divisor});
            end else begin
                r_rem <= trial[cwct_pkg::CNT_W-1:0];
            end
            r_q <= {r_q[cwct_pkg::COORD_W-2:0], q_bit};
        end
    end

    assign o_quotient = r_q;

endmodule

// ----- rtl/core/cwct_ctrl.sv -----
// ============================================================================
// cwct_ctrl
// Sequencer for pixel transactions, end-of-frame division and the result slot.
// ============================================================================
module cwct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_frame_end,
    input  logic            i_out_ready,
    input  cwct_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output cwct_pkg::t_cmd  o_cmd
);

    cwct_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cwct_pkg::S_IDLE: begin
                if (i_in_valid && slot_free && i_frame_end) begin
                    n_state = cwct_pkg::S_LOAD;
                end
            end
            cwct_pkg::S_LOAD: begin
                n_state = cwct_pkg::S_DIV;
            end
            cwct_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = cwct_pkg::S_DONE;
                end
            end
            cwct_pkg::S_DONE: begin
                if (slot_free) begin
                    n_state = cwct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == cwct_pkg::S_IDLE) && slot_free;
        o_cmd.pix_acc    = o_in_ready && i_in_valid;
        o_cmd.div_load   = (r_state == cwct_pkg::S_LOAD);
        o_cmd.div_step   = (r_state == cwct_pkg::S_DIV);
        o_cmd.commit     = (r_state == cwct_pkg::S_DONE) && slot_free;
        if ((o_cmd.pix_acc && !i_frame_end) || o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwct_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/cwct_dpath.sv -----
// ============================================================================
// cwct_dpath
// Color test, window test, hit accumulators, center dividers and result data.
// ============================================================================
module cwct_dpath #(
    parameter int MAX_WIDTH  = cwct_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = cwct_pkg::MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cwct_pkg::t_cmd                   i_cmd,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_red,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_green,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_blue,
    input  logic [cwct_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [cwct_pkg::COORD_W-1:0]     i_pos_y,
    input  logic                             i_frame_end,
    input  logic                             i_cfg_valid,
    input  logic [cwct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_cfg_data,
    output cwct_pkg::t_stat                  o_stat,
    output logic                             o_mask_bit,
    output logic                             o_center_updated,
    output logic [cwct_pkg::COORD_W-1:0]     o_center_x,
    output logic [cwct_pkg::COORD_W-1:0]     o_center_y
);

    logic [cwct_pkg::COLOR_W-1:0] r_br_margin, r_bg_margin, r_blue_floor;
    logic [cwct_pkg::HALF_W-1:0]  r_half;
    logic [cwct_pkg::COORD_W-1:0] r_track_x, r_track_y;
    logic [cwct_pkg::SUM_W-1:0]   r_sum_x, r_sum_y;
    logic [cwct_pkg::CNT_W-1:0]   r_count;
    logic [cwct_pkg::STEP_W-1:0]  r_step;
    logic                         r_mask_hold;

    logic [cwct_pkg::COORD_W-1:0] r_out_cx, r_out_cy;
    logic                         r_out_mask, r_out_upd;

    logic                         mask, in_frame, win_x, win_y, hit;
    logic [cwct_pkg::COORD_W-1:0] quo_x, quo_y, new_cx, new_cy;

    always_comb begin
        mask = ({1'b0, i_blue} > ({1'b0, i_red} + {1'b0, r_br_margin}))
            && ({1'b0, i_blue} > ({1'b0, i_green} + {1'b0, r_bg_margin}))
            && (i_blue > r_blue_floor);
        in_frame = (cwct_pkg::POS_CMP_W'(i_pos_x) < cwct_pkg::POS_CMP_W'(MAX_WIDTH))
            && (cwct_pkg::POS_CMP_W'(i_pos_y) < cwct_pkg::POS_CMP_W'(MAX_HEIGHT));
        // Strict window test rewritten without negative values.
        win_x = ((cwct_pkg::WIN_W'(i_pos_x) + cwct_pkg::WIN_W'(r_half))
                    > cwct_pkg::WIN_W'(r_track_x))
            && (cwct_pkg::WIN_W'(i_pos_x)
                    < (cwct_pkg::WIN_W'(r_track_x) + cwct_pkg::WIN_W'(r_half)));
        win_y = ((cwct_pkg::WIN_W'(i_pos_y) + cwct_pkg::WIN_W'(r_half))
                    > cwct_pkg::WIN_W'(r_track_y))
            && (cwct_pkg::WIN_W'(i_pos_y)
                    < (cwct_pkg::WIN_W'(r_track_y) + cwct_pkg::WIN_W'(r_half)));
        hit = mask && in_frame && win_x && win_y && (r_count != '1);
        new_cx = (r_count == '0) ? r_track_x : quo_x;
        new_cy = (r_count == '0) ? r_track_y : quo_y;
    end

    cwct_div u_div_x (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum_x),
        .i_divisor  (r_count),
        .o_quotient (quo_x)
    );

    cwct_div u_div_y (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_sum_y),
        .i_divisor  (r_count),
        .o_quotient (quo_y)
    );

    assign o_stat.div_done =
        i_cmd.div_step && (r_step == cwct_pkg::STEP_W'(cwct_pkg::COORD_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_br_margin  <= cwct_pkg::MARGIN_RESET;
            r_bg_margin  <= cwct_pkg::MARGIN_RESET;
            r_blue_floor <= cwct_pkg::FLOOR_RESET;
            r_half       <= cwct_pkg::HALF_RESET;
        end else if (i_cfg_valid) begin
            case (cwct_pkg::t_cfg_idx'(i_cfg_index))
                cwct_pkg::CFG_BR_MARGIN:  r_br_margin  <= i_cfg_data;
                cwct_pkg::CFG_BG_MARGIN:  r_bg_margin  <= i_cfg_data;
                cwct_pkg::CFG_BLUE_FLOOR: r_blue_floor <= i_cfg_data;
                cwct_pkg::CFG_WIN_HALF:   r_half       <= i_cfg_data[cwct_pkg::HALF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_x <= cwct_pkg::CENTER_RESET;
            r_track_y <= cwct_pkg::CENTER_RESET;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_count   <= '0;
            r_step    <= '0;
        end else begin
            // The end-of-frame pixel is counted before the division runs.
            if (i_cmd.pix_acc && hit) begin
                r_sum_x <= r_sum_x + cwct_pkg::SUM_W'(i_pos_x);
                r_sum_y <= r_sum_y + cwct_pkg::SUM_W'(i_pos_y);
                r_count <= r_count + 1'b1;
            end else if (i_cmd.commit) begin
                r_track_x <= new_cx;
                r_track_y <= new_cy;
                r_sum_x   <= '0;
                r_sum_y   <= '0;
                r_count   <= '0;
            end
            if (i_cmd.div_load) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_acc && i_frame_end) begin
            r_mask_hold <= mask;
        end
        if (i_cmd.pix_acc && !i_frame_end) begin
            r_out_mask <= mask;
            r_out_upd  <= 1'b0;
            r_out_cx   <= r_track_x;
            r_out_cy   <= r_track_y;
        end else if (i_cmd.commit) begin
            r_out_mask <= r_mask_hold;
            r_out_upd  <= 1'b1;
            r_out_cx   <= new_cx;
            r_out_cy   <= new_cy;
        end
    end

    assign o_mask_bit       = r_out_mask;
    assign o_center_updated = r_out_upd;
    assign o_center_x       = r_out_cx;
    assign o_center_y       = r_out_cy;

endmodule

// ----- rtl/core/color_window_centroid_tracker_unit.sv -----
// ============================================================================
// color_window_centroid_tracker_unit
// Blue-dominant pixel mask and windowed centroid tracking over a pixel stream.
// ============================================================================
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ----------------------------------------
//  pixel in  i_in_valid / o_in_ready   i_red i_green i_blue i_pos_x i_pos_y
//                                      i_frame_end
//  result    o_out_valid / i_out_ready o_mask_bit o_center_updated
//                                      o_center_x o_center_y
//  config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
//  A pixel without the frame-end mark has its result in the output register
//  on the next cycle, and the next pixel can enter meanwhile.
//  A frame-end pixel runs through a load, 10 steps of the restoring
//  dividers (one quotient bit per step for x and y), and a commit.
//  A full output register that is not taken stalls the input side.
//  Reset restores the registers, the center and clears the accumulators.
//
module color_window_centroid_tracker_unit #(
    parameter int MAX_WIDTH  = cwct_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = cwct_pkg::MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_red,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_green,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_blue,
    input  logic [cwct_pkg::COORD_W-1:0]     i_pos_x,
    input  logic [cwct_pkg::COORD_W-1:0]     i_pos_y,
    input  logic                             i_frame_end,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_mask_bit,
    output logic                             o_center_updated,
    output logic [cwct_pkg::COORD_W-1:0]     o_center_x,
    output logic [cwct_pkg::COORD_W-1:0]     o_center_y,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cwct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cwct_pkg::COLOR_W-1:0]     i_cfg_data
);

    `include "color_window_centroid_tracker_unit_macros.svh"

    cwct_pkg::t_cmd  cmd;
    cwct_pkg::t_stat stat;
    logic            in_acc;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    cwct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_frame_end),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cwct_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_frame_end      (i_frame_end),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_stat           (stat),
        .o_mask_bit       (o_mask_bit),
        .o_center_updated (o_center_updated),
        .o_center_x       (o_center_x),
        .o_center_y       (o_center_y)
    );

    // A frame-end transaction keeps the input closed while the dividers run.
    `CWCT_ASSERT_NEXT(a_busy_after_frame_end, in_acc && i_frame_end, !o_in_ready)
    // Input is open only when the result slot is empty or being drained.
    `CWCT_ASSERT_SAME(a_ready_needs_slot, o_in_ready, !o_out_valid || i_out_ready)
    // An ordinary pixel yields its result on the next cycle, without an update mark.
    `CWCT_ASSERT_NEXT(a_pixel_result, in_acc && !i_frame_end, o_out_valid && !o_center_updated)

endmodule

// ----- verif/color_window_centroid_tracker_unit_checker.sv -----
// ============================================================================
// color_window_centroid_tracker_unit_checker
// Watches the pixel, result and register channels of the centroid tracker.
// It keeps its own copy of the thresholds, the tracked center and the window
// sums, works out the result of every accepted pixel, and compares each
// accepted result field by field with the oldest outstanding prediction.
// ============================================================================
module color_window_centroid_tracker_unit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [cwct_pkg::COLOR_W-1:0]   i_red,
    input  logic [cwct_pkg::COLOR_W-1:0]   i_green,
    input  logic [cwct_pkg::COLOR_W-1:0]   i_blue,
    input  logic [cwct_pkg::COORD_W-1:0]   i_pos_x,
    input  logic [cwct_pkg::COORD_W-1:0]   i_pos_y,
    input  logic                           i_frame_end,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_mask_bit,
    input  logic                           i_center_updated,
    input  logic [cwct_pkg::COORD_W-1:0]   i_center_x,
    input  logic [cwct_pkg::COORD_W-1:0]   i_center_y,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cwct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cwct_pkg::COLOR_W-1:0]   i_cfg_data,
    output int                             o_error_count,
    output int                             o_pending,
    output logic [cwct_pkg::COORD_W-1:0]   o_track_x,
    output logic [cwct_pkg::COORD_W-1:0]   o_track_y
);

    typedef struct packed {
        logic                         mask_bit;
        logic                         center_updated;
        logic [cwct_pkg::COORD_W-1:0] center_x;
        logic [cwct_pkg::COORD_W-1:0] center_y;
    } t_pixel_result;

    logic [cwct_pkg::COLOR_W-1:0] br_margin  = cwct_pkg::MARGIN_RESET;
    logic [cwct_pkg::COLOR_W-1:0] bg_margin  = cwct_pkg::MARGIN_RESET;
    logic [cwct_pkg::COLOR_W-1:0] blue_floor = cwct_pkg::FLOOR_RESET;
    logic [cwct_pkg::HALF_W-1:0]  win_half   = cwct_pkg::HALF_RESET;
    logic [cwct_pkg::COORD_W-1:0] track_x    = cwct_pkg::CENTER_RESET;
    logic [cwct_pkg::COORD_W-1:0] track_y    = cwct_pkg::CENTER_RESET;
    logic [31:0]                  sum_x      = '0;
    logic [31:0]                  sum_y      = '0;
    logic [cwct_pkg::CNT_W-1:0]   hit_count  = '0;

    t_pixel_result centroid_q[$];
    int            error_count   = 0;
    int            results_taken = 0;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        o_track_x     = cwct_pkg::CENTER_RESET;
        o_track_y     = cwct_pkg::CENTER_RESET;
    end

    // Classifies one pixel, accumulates it when it is blue-dominant inside the window and
    // closes the frame on the end mark. Returns what the block must report.
    function automatic t_pixel_result track_pixel(
        input logic [cwct_pkg::COLOR_W-1:0] red,
        input logic [cwct_pkg::COLOR_W-1:0] green,
        input logic [cwct_pkg::COLOR_W-1:0] blue,
        input logic [cwct_pkg::COORD_W-1:0] pos_x,
        input logic [cwct_pkg::COORD_W-1:0] pos_y,
        input logic                         frame_end
    );
        int            half;
        int            cx;
        int            cy;
        logic          blue_dominant;
        logic          in_window;
        t_pixel_result res;
        half = int'(win_half);
        cx   = int'(track_x);
        cy   = int'(track_y);
        blue_dominant = (int'(blue) - int'(red) > int'(br_margin))
                     && (int'(blue) - int'(green) > int'(bg_margin))
                     && (int'(blue) > int'(blue_floor));
        in_window = (int'(pos_x) < cwct_pkg::MAX_WIDTH)
                 && (int'(pos_y) < cwct_pkg::MAX_HEIGHT)
                 && (cx - half < int'(pos_x)) && (int'(pos_x) < cx + half)
                 && (cy - half < int'(pos_y)) && (int'(pos_y) < cy + half);
        // A saturated count freezes the sums too, so the mean stays consistent.
        if (blue_dominant && in_window && hit_count != {cwct_pkg::CNT_W{1'b1}}) begin
            sum_x     = sum_x + 32'(pos_x);
            sum_y     = sum_y + 32'(pos_y);
            hit_count = hit_count + 1'b1;
        end
        if (frame_end) begin
            if (hit_count != '0) begin
                track_x = cwct_pkg::COORD_W'(sum_x / 32'(hit_count));
                track_y = cwct_pkg::COORD_W'(sum_y / 32'(hit_count));
            end
            sum_x     = '0;
            sum_y     = '0;
            hit_count = '0;
        end
        res.mask_bit       = blue_dominant;
        res.center_updated = frame_end;
        res.center_x       = track_x;
        res.center_y       = track_y;
        return res;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: centroid mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_pixel_result seen;
        t_pixel_result want;
        if (!i_rst_n) begin
            br_margin  = cwct_pkg::MARGIN_RESET;
            bg_margin  = cwct_pkg::MARGIN_RESET;
            blue_floor = cwct_pkg::FLOOR_RESET;
            win_half   = cwct_pkg::HALF_RESET;
            track_x    = cwct_pkg::CENTER_RESET;
            track_y    = cwct_pkg::CENTER_RESET;
            sum_x      = '0;
            sum_y      = '0;
            hit_count  = '0;
            centroid_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cwct_pkg::CFG_BR_MARGIN:  br_margin  = i_cfg_data;
                    cwct_pkg::CFG_BG_MARGIN:  bg_margin  = i_cfg_data;
                    cwct_pkg::CFG_BLUE_FLOOR: blue_floor = i_cfg_data;
                    cwct_pkg::CFG_WIN_HALF:   win_half   = i_cfg_data[cwct_pkg::HALF_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen = '{i_mask_bit, i_center_updated, i_center_x, i_center_y};
                if (centroid_q.size() == 0) begin
                    note_error({$sformatf("result %0d with nothing outstanding: ",
                        results_taken),
                        $sformatf("mask=%0b upd=%0b x=%0d y=%0d", seen.mask_bit,
                        seen.center_updated, seen.center_x, seen.center_y)});
                end else begin
                    want = centroid_q.pop_front();
                    if (seen.mask_bit !== want.mask_bit
                            || seen.center_updated !== want.center_updated
                            || seen.center_x !== want.center_x
                            || seen.center_y !== want.center_y) begin
                        note_error({$sformatf("result %0d: expected mask=%0b upd=%0b ",
                            results_taken, want.mask_bit, want.center_updated),
                            $sformatf("x=%0d y=%0d, got mask=%0b upd=%0b x=%0d y=%0d",
                            want.center_x, want.center_y, seen.mask_bit,
                            seen.center_updated, seen.center_x, seen.center_y)});
                    end
                end
                results_taken++;
            end
            if (i_in_valid && i_in_ready)
                centroid_q.push_back(track_pixel(i_red, i_green, i_blue,
                                                 i_pos_x, i_pos_y, i_frame_end));
        end
        o_error_count <= error_count;
        o_pending     <= centroid_q.size();
        o_track_x     <= track_x;
        o_track_y     <= track_y;
    end

endmodule

// ----- verif/color_window_centroid_tracker_unit_test.sv -----
// ============================================================================
// color_window_centroid_tracker_unit_test
// Drives pixel frames and threshold settings into the centroid tracker with
// random gaps on the pixel side and random stalls on the result side. A
// checker beside the block predicts every result; this module only makes the
// stimulus and gives the verdict.
// ============================================================================
module color_window_centroid_tracker_unit_test;

    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 16;
    localparam int COORD_MAX     = (1 << cwct_pkg::COORD_W) - 1;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic [cwct_pkg::COLOR_W-1:0]   i_red       = '0;
    logic [cwct_pkg::COLOR_W-1:0]   i_green     = '0;
    logic [cwct_pkg::COLOR_W-1:0]   i_blue      = '0;
    logic [cwct_pkg::COORD_W-1:0]   i_pos_x     = '0;
    logic [cwct_pkg::COORD_W-1:0]   i_pos_y     = '0;
    logic                           i_frame_end = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic                           o_mask_bit;
    logic                           o_center_updated;
    logic [cwct_pkg::COORD_W-1:0]   o_center_x;
    logic [cwct_pkg::COORD_W-1:0]   o_center_y;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [cwct_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cwct_pkg::COLOR_W-1:0]   i_cfg_data  = '0;

    int                             error_count;
    int                             pending;
    logic [cwct_pkg::COORD_W-1:0]   track_x;
    logic [cwct_pkg::COORD_W-1:0]   track_y;

    // Thresholds as last written, used to aim pixels at the color test.
    int cur_br    = int'(cwct_pkg::MARGIN_RESET);
    int cur_bg    = int'(cwct_pkg::MARGIN_RESET);
    int cur_floor = int'(cwct_pkg::FLOOR_RESET);
    int cur_half  = int'(cwct_pkg::HALF_RESET);

    logic calm        = 1'b0;
    int   calm_left   = 0;
    int   stall_left  = 0;
    int   idle_cycles = 0;

    color_window_centroid_tracker_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_frame_end      (i_frame_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mask_bit       (o_mask_bit),
        .o_center_updated (o_center_updated),
        .o_center_x       (o_center_x),
        .o_center_y       (o_center_y),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    color_window_centroid_tracker_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_frame_end      (i_frame_end),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_mask_bit       (o_mask_bit),
        .i_center_updated (o_center_updated),
        .i_center_x       (o_center_x),
        .i_center_y       (o_center_y),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_error_count    (error_count),
        .o_pending        (pending),
        .o_track_x        (track_x),
        .o_track_y        (track_y)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [cwct_pkg::COLOR_W-1:0] to_color(input int v);
        return cwct_pkg::COLOR_W'(v);
    endfunction

    function automatic logic [cwct_pkg::COORD_W-1:0] to_coord(input int v);
        return cwct_pkg::COORD_W'(v);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Result side: random stalls, interrupted by calm stretches without any.
    always @(posedge i_clk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            i_out_ready <= 1'b0;
            stall_left  <= pick_gap() - 1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("color_window_centroid_tracker_unit_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(
        input logic [cwct_pkg::COLOR_W-1:0] red,
        input logic [cwct_pkg::COLOR_W-1:0] green,
        input logic [cwct_pkg::COLOR_W-1:0] blue,
        input logic [cwct_pkg::COORD_W-1:0] pos_x,
        input logic [cwct_pkg::COORD_W-1:0] pos_y,
        input logic                         frame_end
    );
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 25)
            gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_red       <= red;
        i_green     <= green;
        i_blue      <= blue;
        i_pos_x     <= pos_x;
        i_pos_y     <= pos_y;
        i_frame_end <= frame_end;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every predicted result has come back, then lets the
    // divider pipeline drain before anything else happens.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_thresholds(
        input logic [cwct_pkg::COLOR_W-1:0] br,
        input logic [cwct_pkg::COLOR_W-1:0] bg,
        input logic [cwct_pkg::COLOR_W-1:0] floor_val,
        input logic [cwct_pkg::COLOR_W-1:0] half_data
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= cwct_pkg::CFG_BR_MARGIN;
        i_cfg_data  <= br;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= cwct_pkg::CFG_BG_MARGIN;
        i_cfg_data  <= bg;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= cwct_pkg::CFG_BLUE_FLOOR;
        i_cfg_data  <= floor_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= cwct_pkg::CFG_WIN_HALF;
        i_cfg_data  <= half_data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_br    = int'(br);
        cur_bg    = int'(bg);
        cur_floor = int'(floor_val);
        cur_half  = int'(half_data[cwct_pkg::HALF_W-1:0]);
    endtask

    // One frame: mostly blue pixels scattered around the tracked center,
    // with some fully random pixels that may also cut the frame short.
    task automatic send_frame(input int len);
        int x;
        int y;
        int r;
        int g;
        int b;
        int lim;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 80) begin
                x = int'(track_x) - cur_half - 2 + $urandom_range(0, 2 * cur_half + 4);
                y = int'(track_y) - cur_half - 2 + $urandom_range(0, 2 * cur_half + 4);
                x = (x < 0) ? 0 : (x > COORD_MAX) ? COORD_MAX : x;
                y = (y < 0) ? 0 : (y > COORD_MAX) ? COORD_MAX : y;
                b = (cur_floor >= 255) ? 255 : $urandom_range(cur_floor + 1, 255);
                lim = b - cur_br - 1;
                r = (lim < 0) ? $urandom_range(0, 255) : $urandom_range(0, lim);
                lim = b - cur_bg - 1;
                g = (lim < 0) ? $urandom_range(0, 255) : $urandom_range(0, lim);
                send_pixel(to_color(r), to_color(g), to_color(b),
                           to_coord(x), to_coord(y), i == len - 1);
            end else begin
                send_pixel(to_color($urandom_range(0, 255)), to_color($urandom_range(0, 255)),
                           to_color($urandom_range(0, 255)),
                           to_coord($urandom_range(0, COORD_MAX)),
                           to_coord($urandom_range(0, COORD_MAX)),
                           (i == len - 1) || ($urandom_range(0, 9) == 0));
            end
        end
    endtask

    initial begin
        int                           sent;
        int                           len;
        logic [cwct_pkg::COORD_W-1:0] tx;
        logic [cwct_pkg::COORD_W-1:0] ty;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes, an empty frame, window edges and color test edges.
        tx = track_x;
        ty = track_y;
        send_pixel(to_color(0), to_color(0), to_color(0), to_coord(0), to_coord(0), 1'b0);
        send_pixel(to_color(255), to_color(255), to_color(255),
                   to_coord(COORD_MAX), to_coord(COORD_MAX), 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(0), to_coord(500), to_coord(500), 1'b1);
        send_pixel(to_color(0), to_color(0), to_color(255), tx - to_coord(65), ty, 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255), tx + to_coord(65), ty, 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255), tx, ty - to_coord(65), 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255),
                   tx - to_coord(64), ty + to_coord(20), 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255),
                   tx + to_coord(64), ty - to_coord(20), 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255),
                   tx + to_coord(3), ty + to_coord(64), 1'b0);
        send_pixel(to_color(178), to_color(0), to_color(200), tx, ty, 1'b0);
        send_pixel(to_color(179), to_color(0), to_color(200), tx, ty, 1'b0);
        send_pixel(to_color(0), to_color(178), to_color(200), tx, ty, 1'b0);
        send_pixel(to_color(0), to_color(179), to_color(200), tx, ty, 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(170), tx, ty, 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(171), tx, ty, 1'b0);
        send_pixel(to_color(255), to_color(0), to_color(100), tx, ty, 1'b0);
        send_pixel(to_color(0), to_color(0), to_color(255),
                   tx + to_coord(40), ty - to_coord(30), 1'b1);
        send_pixel(to_color(0), to_color(0), to_color(255),
                   to_coord(COORD_MAX), to_coord(COORD_MAX), 1'b1);
        drain_results();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
                1: set_thresholds(8'd255, 8'd255, 8'd255, 8'hFF);
                2: set_thresholds(8'd0, 8'd0, 8'd0, 8'h7F);
                3: set_thresholds(cwct_pkg::MARGIN_RESET, cwct_pkg::MARGIN_RESET,
                                  cwct_pkg::FLOOR_RESET, 8'd65);
                4: set_thresholds(to_color($urandom_range(0, 80)),
                                  to_color($urandom_range(0, 80)),
                                  to_color($urandom_range(0, 240)), 8'd100);
                default: set_thresholds(to_color($urandom_range(0, 80)),
                                        to_color($urandom_range(0, 80)),
                                        to_color($urandom_range(0, 240)),
                                        to_color($urandom_range(0, 255)));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
                send_frame(len);
                sent += len;
            end
            drain_results();
        end

        if (error_count == 0 && pending == 0)
            $display("color_window_centroid_tracker_unit_test: clean");
        else
            $display("color_window_centroid_tracker_unit_test: errors");
        $finish;
    end

endmodule

// ----- color_window_centroid_tracker_unit.f -----
+incdir+rtl/core
rtl/core/cwct_pkg.sv
rtl/core/cwct_div.sv
rtl/core/cwct_ctrl.sv
rtl/core/cwct_dpath.sv
rtl/core/color_window_centroid_tracker_unit.sv
verif/color_window_centroid_tracker_unit_checker.sv
verif/color_window_centroid_tracker_unit_test.sv
